// ===== sv/pi_closed_loop_euler_step_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the PI closed-loop Euler step block
// Clocked immediate-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef PI_CLOSED_LOOP_EULER_STEP_ASSERT_SVH
`define PI_CLOSED_LOOP_EULER_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCES_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pces_pkg.sv =====
// ----------------------------------------------------------------------------
// pces_pkg
// Constants, types and saturating helpers for the PI closed-loop Euler step.
// ----------------------------------------------------------------------------
`default_nettype none

package pces_pkg;

   localparam int unsigned FRAC_BITS_DEF = 16;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned INDEX_W       = 16;
   localparam int unsigned CSR_INDEX_W   = 3;

   // serial multiplier: one digit of the multiplier per cycle
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned DIGIT_COUNT = WORD_W / DIGIT_W;
   localparam int unsigned DIG_CNT_W   = $clog2(DIGIT_COUNT);
   localparam int unsigned MAC_W       = WORD_W + DIGIT_W + 1;
   localparam logic [DIG_CNT_W-1:0] DIGIT_LAST = DIG_CNT_W'(DIGIT_COUNT - 1);

   localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [33:0] WIDE_MAX = 34'sd2147483647;
   localparam logic signed [33:0] WIDE_MIN = -34'sd2147483648;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_PLANT_A    = 3'd0,
      CFG_PLANT_B    = 3'd1,
      CFG_INIT_STATE = 3'd2,
      CFG_TIME_STEP  = 3'd3,
      CFG_PROP_GAIN  = 3'd4,
      CFG_INTEG_GAIN = 3'd5,
      CFG_RUN_LENGTH = 3'd6
   } cfg_index_type;

   // one product per operation, in evaluation order
   typedef enum logic [2:0] {
      OP_INTEG = 3'd0,  // x * |dt|, accumulate into integral
      OP_PROP  = 3'd1,  // kp * x
      OP_CTRL  = 3'd2,  // ki * integral, form u
      OP_PLANT = 3'd3,  // a * x
      OP_INPUT = 3'd4,  // b * u, form derivative
      OP_STATE = 3'd5   // |dt| * derivative, update x
   } op_type;

   typedef struct packed {
      logic                     sat;
      logic signed [WORD_W-1:0] value;
   } sat_word_type;

   function automatic sat_word_type clamp_wide(input logic signed [33:0] v);
      sat_word_type r;
      r.sat   = 1'b0;
      r.value = v[WORD_W-1:0];
      if (v > WIDE_MAX) begin
         r.sat   = 1'b1;
         r.value = Q_MAX;
      end else if (v < WIDE_MIN) begin
         r.sat   = 1'b1;
         r.value = Q_MIN;
      end
      return r;
   endfunction

   function automatic sat_word_type sat_add(input logic signed [WORD_W-1:0] a,
                                            input logic signed [WORD_W-1:0] b);
      return clamp_wide(34'(a) + 34'(b));
   endfunction

   // -a - b, saturated
   function automatic sat_word_type sat_neg_sum(input logic signed [WORD_W-1:0] a,
                                                input logic signed [WORD_W-1:0] b);
      return clamp_wide(-34'(a) - 34'(b));
   endfunction

   function automatic sat_word_type sat_abs(input logic signed [WORD_W-1:0] a);
      sat_word_type r;
      r.sat   = 1'b0;
      r.value = a;
      if (a == Q_MIN) begin
         r.sat   = 1'b1;
         r.value = Q_MAX;
      end else if (a < 0) begin
         r.value = -a;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/pi_closed_loop_euler_step.sv =====
// ----------------------------------------------------------------------------
// pi_closed_loop_euler_step
// First-order plant under PI control, one forward-Euler step per transaction.
// ----------------------------------------------------------------------------
// Each request transaction either restarts the run (req_restart = 1) or asks
// for one Euler step; every request gives exactly one response transaction.
// A restart, or a step request once the step index has reached run_length,
// is answered without any product: it goes straight to S_FIN, which loads
// the response register once it is free, and back to S_IDLE. A real step
// performs six signed Q(32-FRAC_BITS).FRAC_BITS products on one shared
// digit-serial multiplier that consumes four multiplier bits per cycle:
// each product runs through eight digits in S_MUL and is written back in
// S_WB; the sixth write-back leads to S_FIN and the response register. The
// next request is taken only once the block is back in S_IDLE.
// The block works on one request at a time; req_stall is high while a
// request is in progress, but a finished response that waits on rsp_stall
// does not hold off the next request. Products are floored and saturated,
// sums saturated; rsp_saturated flags any clipping in the step.
// The user must write configuration registers through csr_wr_en / csr_index /
// csr_wr_data only while idle (not enforced); unknown indices are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_closed_loop_euler_step
   import pces_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_restart,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [WORD_W-1:0]      rsp_state_value,
   output logic        [INDEX_W-1:0]     rsp_step_index,
   output logic                          rsp_run_done,
   output logic                          rsp_saturated,
   // configuration write port
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [WORD_W-1:0]        csr_wr_data
);

   `include "pi_closed_loop_euler_step_assert.svh"

   localparam logic signed [WORD_W-1:0] TIME_STEP_RESET = 32'(64'd1 << FRAC_BITS);
   localparam int unsigned TOP_SHIFT = FRAC_BITS + WORD_W - 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,  // wait for a request
      S_MUL  = 4'b0010,  // run the serial multiplier
      S_WB   = 4'b0100,  // write the product back, then start the next one or finish
      S_FIN  = 4'b1000   // hand the result to the response register
   } state_type;

   // configuration
   logic signed [WORD_W-1:0]  plant_a_ff, plant_a_in;
   logic signed [WORD_W-1:0]  plant_b_ff, plant_b_in;
   logic signed [WORD_W-1:0]  init_state_ff, init_state_in;
   logic signed [WORD_W-1:0]  time_step_ff, time_step_in;
   logic signed [WORD_W-1:0]  prop_gain_ff, prop_gain_in;
   logic signed [WORD_W-1:0]  integ_gain_ff, integ_gain_in;
   logic        [INDEX_W-1:0] run_length_ff, run_length_in;

   // plant and controller state
   logic signed [WORD_W-1:0]  x_ff, x_in;
   logic signed [WORD_W-1:0]  integ_ff, integ_in;
   logic        [INDEX_W-1:0] cnt_ff, cnt_in;

   // step working registers
   logic signed [WORD_W-1:0]  adt_ff, adt_in;     // |dt|
   logic signed [WORD_W-1:0]  t1_ff, t1_in;       // kp*x, then u
   logic signed [WORD_W-1:0]  t2_ff, t2_in;       // a*x, then derivative
   logic                      done_pend_ff, done_pend_in;
   logic                      sat_pend_ff, sat_pend_in;

   // serial multiplier
   logic signed [WORD_W-1:0]  mcand_ff, mcand_in;
   logic signed [WORD_W-1:0]  hi_ff, hi_in;
   logic        [WORD_W-1:0]  lo_ff, lo_in;
   logic [DIG_CNT_W-1:0]      dig_ff, dig_in;
   op_type                    op_ff, op_in;
   state_type                 state_ff, state_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0]  rsp_state_ff, rsp_state_in;
   logic        [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                      rsp_done_ff, rsp_done_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   // datapath
   logic signed [MAC_W-1:0]   mcand_ext;
   logic signed [MAC_W-1:0]   digit_ext;
   logic signed [MAC_W-1:0]   mac_sum;
   logic signed [63:0]        prod_full;
   logic signed [63:0]        prod_top;
   sat_word_type              q_word;
   sat_word_type              abs_word;
   sat_word_type              sum_word;
   logic                      load_mul;
   logic signed [WORD_W-1:0]  next_mcand;
   logic signed [WORD_W-1:0]  next_mult;
   logic        [INDEX_W-1:0] cnt_inc;

   // One digit step: add mcand * digit to the upper half, then shift the
   // pair right by one digit. The top digit of the multiplier is signed.
   always_comb begin
      mcand_ext = MAC_W'(mcand_ff);
      digit_ext = MAC_W'($signed({lo_ff[DIGIT_W-1] & (dig_ff == DIGIT_LAST),
                                  lo_ff[DIGIT_W-1:0]}));
      mac_sum   = MAC_W'(hi_ff) + mcand_ext * digit_ext;
   end

   // Floor-shifted, saturated product once all digits are in
   always_comb begin
      prod_full    = {hi_ff, lo_ff};
      prod_top     = prod_full >>> TOP_SHIFT;
      q_word.sat   = !((prod_top == '0) || (prod_top == '1));
      q_word.value = prod_full[FRAC_BITS+WORD_W-1:FRAC_BITS];
      if (q_word.sat) begin
         q_word.value = prod_full[63] ? Q_MIN : Q_MAX;
      end
   end

   assign abs_word = sat_abs(time_step_ff);
   assign cnt_inc  = cnt_ff + INDEX_W'(1);

   always_comb begin
      plant_a_in    = plant_a_ff;
      plant_b_in    = plant_b_ff;
      init_state_in = init_state_ff;
      time_step_in  = time_step_ff;
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      run_length_in = run_length_ff;
      x_in          = x_ff;
      integ_in      = integ_ff;
      cnt_in        = cnt_ff;
      adt_in        = adt_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      done_pend_in  = done_pend_ff;
      sat_pend_in   = sat_pend_ff;
      mcand_in      = mcand_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      dig_in        = dig_ff;
      op_in         = op_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_sat_in    = rsp_sat_ff;
      sum_word      = '0;
      load_mul      = 1'b0;
      next_mcand    = '0;
      next_mult     = '0;

      if (csr_wr_en) begin
         case (csr_index)
            CFG_PLANT_A:    plant_a_in    = csr_wr_data;
            CFG_PLANT_B:    plant_b_in    = csr_wr_data;
            CFG_INIT_STATE: init_state_in = csr_wr_data;
            CFG_TIME_STEP:  time_step_in  = csr_wr_data;
            CFG_PROP_GAIN:  prop_gain_in  = csr_wr_data;
            CFG_INTEG_GAIN: integ_gain_in = csr_wr_data;
            CFG_RUN_LENGTH: run_length_in = csr_wr_data[INDEX_W-1:0];
            default:        ;
         endcase
      end

      // drop the response once it has been taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  x_in         = init_state_ff;
                  integ_in     = '0;
                  cnt_in       = '0;
                  done_pend_in = (run_length_ff == '0);
                  sat_pend_in  = 1'b0;
                  state_in     = S_FIN;
               end else if (cnt_ff >= run_length_ff) begin
                  // run over: hold state and index
                  done_pend_in = 1'b1;
                  sat_pend_in  = 1'b0;
                  state_in     = S_FIN;
               end else begin
                  adt_in      = abs_word.value;
                  sat_pend_in = abs_word.sat;
                  op_in       = OP_INTEG;
                  load_mul    = 1'b1;
                  state_in    = S_MUL;
               end
            end
         end
         S_MUL: begin
            hi_in  = mac_sum[WORD_W+DIGIT_W-1:DIGIT_W];
            lo_in  = {mac_sum[DIGIT_W-1:0], lo_ff[WORD_W-1:DIGIT_W]};
            dig_in = dig_ff + DIG_CNT_W'(1);
            if (dig_ff == DIGIT_LAST) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            case (op_ff)
               OP_INTEG: begin
                  sum_word    = sat_add(integ_ff, q_word.value);
                  integ_in    = sum_word.value;
                  sat_pend_in = sat_pend_ff | q_word.sat | sum_word.sat;
               end
               OP_PROP: begin
                  t1_in       = q_word.value;
                  sat_pend_in = sat_pend_ff | q_word.sat;
               end
               OP_CTRL: begin
                  sum_word    = sat_neg_sum(t1_ff, q_word.value);
                  t1_in       = sum_word.value;
                  sat_pend_in = sat_pend_ff | q_word.sat | sum_word.sat;
               end
               OP_PLANT: begin
                  t2_in       = q_word.value;
                  sat_pend_in = sat_pend_ff | q_word.sat;
               end
               OP_INPUT: begin
                  sum_word    = sat_add(t2_ff, q_word.value);
                  t2_in       = sum_word.value;
                  sat_pend_in = sat_pend_ff | q_word.sat | sum_word.sat;
               end
               OP_STATE: begin
                  sum_word    = sat_add(x_ff, q_word.value);
                  x_in        = sum_word.value;
                  sat_pend_in = sat_pend_ff | q_word.sat | sum_word.sat;
               end
               default: ;
            endcase
            if (op_ff == OP_STATE) begin
               cnt_in       = cnt_inc;
               done_pend_in = (cnt_inc == run_length_ff);
               state_in     = S_FIN;
            end else begin
               op_in    = op_type'(op_ff + 3'd1);
               load_mul = 1'b1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            // wait for the response register to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = x_ff;
               rsp_index_in = cnt_ff;
               rsp_done_in  = done_pend_ff;
               rsp_sat_in   = sat_pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Operands for the next product, taken from the values written this
      // cycle so that a result feeds straight into the following product.
      case (op_in)
         OP_INTEG: begin
            next_mcand = x_ff;
            next_mult  = adt_in;
         end
         OP_PROP: begin
            next_mcand = prop_gain_ff;
            next_mult  = x_ff;
         end
         OP_CTRL: begin
            next_mcand = integ_gain_ff;
            next_mult  = integ_in;
         end
         OP_PLANT: begin
            next_mcand = plant_a_ff;
            next_mult  = x_ff;
         end
         OP_INPUT: begin
            next_mcand = plant_b_ff;
            next_mult  = t1_in;
         end
         OP_STATE: begin
            next_mcand = adt_in;
            next_mult  = t2_in;
         end
         default: begin
            next_mcand = '0;
            next_mult  = '0;
         end
      endcase

      if (load_mul) begin
         mcand_in = next_mcand;
         hi_in    = '0;
         lo_in    = next_mult;
         dig_in   = '0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         plant_a_ff    <= '0;
         plant_b_ff    <= '0;
         init_state_ff <= '0;
         time_step_ff  <= TIME_STEP_RESET;
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         run_length_ff <= '0;
         x_ff          <= '0;
         integ_ff      <= '0;
         cnt_ff        <= '0;
         dig_ff        <= '0;
         op_ff         <= OP_INTEG;
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         plant_a_ff    <= plant_a_in;
         plant_b_ff    <= plant_b_in;
         init_state_ff <= init_state_in;
         time_step_ff  <= time_step_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         run_length_ff <= run_length_in;
         x_ff          <= x_in;
         integ_ff      <= integ_in;
         cnt_ff        <= cnt_in;
         dig_ff        <= dig_in;
         op_ff         <= op_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      adt_ff       <= adt_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      done_pend_ff <= done_pend_in;
      sat_pend_ff  <= sat_pend_in;
      mcand_ff     <= mcand_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      rsp_state_ff <= rsp_state_in;
      rsp_index_ff <= rsp_index_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_state_value = rsp_state_ff;
   assign rsp_step_index  = rsp_index_ff;
   assign rsp_run_done    = rsp_done_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // conditions watched by the checks below
   logic last_digit;
   logic tick_past_end;
   logic tick_held;
   logic final_wb;
   logic mul_parked;

   assign last_digit    = (state_ff == S_MUL) && (dig_ff == DIGIT_LAST);
   assign tick_past_end = req_valid && !req_stall && !req_restart &&
                          (cnt_ff >= run_length_ff);
   assign tick_held     = (state_ff == S_FIN) && done_pend_ff;
   assign final_wb      = (state_ff == S_WB) && (op_ff == OP_STATE);
   assign mul_parked    = (state_ff == S_IDLE) || (state_ff == S_FIN);

   // the last digit of a product always leads to its write-back
   `PCES_ASSERT_NEXT(a_mul_ends_in_wb, clock, reset, last_digit, state_ff == S_WB, "no write-back")
   // a step request past the end of the run is answered as done without work
   `PCES_ASSERT_NEXT(a_hold_tick_done, clock, reset, tick_past_end, tick_held, "tick not held")
   // the final write-back of a step advances the index by one
   `PCES_ASSERT_NEXT(a_index_step, clock, reset, final_wb, cnt_ff == $past(cnt_ff) + 1'b1, "index held")
   // the digit counter is parked at zero while idle or handing off a result
   `PCES_ASSERT_NOW(a_digit_idle_zero, clock, reset, mul_parked, dig_ff == '0, "digit not parked")

endmodule

`default_nettype wire
